@@ rtl/core/fw2d_pkg.sv @@
// Shared widths, codes and defaults of the two-dimensional prefix maximum table.
`timescale 1ns / 1ps

package fw2d_pkg;

    localparam int X_SIZE_DEF     = 256;
    localparam int Y_SIZE_DEF     = 512;
    localparam int VALUE_BITS_DEF = 16;

    localparam int X_COORD_BITS   = 9;
    localparam int Y_COORD_BITS   = 10;
    localparam int NEW_VALUE_BITS = 16;
    localparam int MAX_BITS       = 16;

    localparam int X_LIMIT_BITS   = 9;
    localparam int Y_LIMIT_BITS   = 10;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 10;

    localparam logic [X_LIMIT_BITS-1:0] X_LIMIT_RST = X_LIMIT_BITS'(256);
    localparam logic [Y_LIMIT_BITS-1:0] Y_LIMIT_RST = Y_LIMIT_BITS'(512);

    typedef enum logic
    {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } cfg_reg_t;

endpackage

@@ rtl/core/fw2d_if.sv @@
// Request and response channel interfaces of the prefix maximum table.
`timescale 1ns / 1ps

interface fw2d_req_if import fw2d_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [X_COORD_BITS-1:0]   x_coord;
    logic [Y_COORD_BITS-1:0]   y_coord;
    logic [NEW_VALUE_BITS-1:0] new_value;

    modport source (output valid, output op, output x_coord, output y_coord,
                    output new_value, input ready);
    modport sink (input valid, input op, input x_coord, input y_coord,
                  input new_value, output ready);
endinterface

interface fw2d_rsp_if import fw2d_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MAX_BITS-1:0] max_found;
    logic                bad_index;

    modport source (output valid, output max_found, output bad_index, input ready);
    modport sink (input valid, input max_found, input bad_index, output ready);
endinterface

@@ rtl/core/fw2d_ram.sv @@
// Node memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fw2d_ram
#(
    parameter int DEPTH = 131072,
    parameter int AW    = 17,
    parameter int DW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/fw2d_walk.sv @@
// Walk sequencer: clearing pass, query and update walks, response register.
`timescale 1ns / 1ps

module fw2d_walk import fw2d_pkg::*;
#(
    parameter int X_SIZE     = X_SIZE_DEF,
    parameter int Y_SIZE     = Y_SIZE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int XLW        = $clog2(X_SIZE + 1),
    parameter int YLW        = $clog2(Y_SIZE + 1),
    parameter int AW         = $clog2(X_SIZE * Y_SIZE)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fw2d_req_if.sink              req,
    fw2d_rsp_if.source            rsp,
    input  logic [XLW-1:0]        x_lim,
    input  logic [YLW-1:0]        y_lim,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [VALUE_BITS-1:0] mem_rdata
);

    localparam int DEPTH = X_SIZE * Y_SIZE;
    localparam int XCW   = (X_COORD_BITS > XLW) ? X_COORD_BITS : XLW;
    localparam int YCW   = (Y_COORD_BITS > YLW) ? Y_COORD_BITS : YLW;
    localparam int XIW   = XCW + 1;
    localparam int YIW   = YCW + 1;
    localparam int XAW   = (X_SIZE > 1) ? $clog2(X_SIZE) : 1;
    localparam int YAW   = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_reg, op_next;
    logic [XIW-1:0]        xi_reg, xi_next;
    logic [YIW-1:0]        yi_reg, yi_next;
    logic [YIW-1:0]        ys_reg, ys_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic                  bad_reg, bad_next;
    logic                  more_reg, more_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [MAX_BITS-1:0]   rsp_max_reg, rsp_max_next;
    logic                  rsp_bad_reg, rsp_bad_next;

    logic [XIW-1:0]        xc_ext, xs_clamp, xl_ext, x_low, x_step;
    logic [YIW-1:0]        yc_ext, ys_clamp, yl_ext, y_low, y_step;
    logic                  y_wrap, x_end;
    logic [XAW-1:0]        x_ofs;
    logic [YAW-1:0]        y_ofs;
    logic [AW-1:0]         node_addr;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.max_found = rsp_max_reg;
    assign rsp.bad_index = rsp_bad_reg;

    assign xc_ext   = XIW'(req.x_coord);
    assign yc_ext   = YIW'(req.y_coord);
    assign xl_ext   = XIW'(x_lim);
    assign yl_ext   = YIW'(y_lim);
    assign xs_clamp = (xc_ext > XIW'(X_SIZE)) ? XIW'(X_SIZE) : xc_ext;
    assign ys_clamp = (yc_ext > YIW'(Y_SIZE)) ? YIW'(Y_SIZE) : yc_ext;

    assign x_low = xi_reg & (~xi_reg + XIW'(1));
    assign y_low = yi_reg & (~yi_reg + YIW'(1));

    always_comb
    begin
        if (op_reg == OP_UPDATE)
        begin
            x_step = xi_reg + x_low;
            y_step = yi_reg + y_low;
            y_wrap = (y_step > yl_ext);
            x_end  = (x_step > xl_ext);
        end
        else
        begin
            x_step = xi_reg - x_low;
            y_step = yi_reg - y_low;
            y_wrap = (y_step == '0);
            x_end  = (x_step == '0);
        end
    end

    assign x_ofs     = XAW'(xi_reg - XIW'(1));
    assign y_ofs     = YAW'(yi_reg - YIW'(1));
    assign node_addr = AW'(x_ofs) * AW'(Y_SIZE) + AW'(y_ofs);

    assign mem_re    = (state_reg == ST_WALK) && more_reg;
    assign mem_raddr = node_addr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = val_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == ST_WALK) && pend_reg && (op_reg == OP_UPDATE)
                 && (mem_rdata < val_reg))
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        ys_next        = ys_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        bad_next       = bad_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        clr_addr_next  = clr_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_max_next   = rsp_max_reg;
        rsp_bad_next   = rsp_bad_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.op;
                    val_next  = VALUE_BITS'(req.new_value);
                    best_next = '0;
                    pend_next = 1'b0;
                    if (req.op == OP_UPDATE)
                    begin
                        bad_next  = (req.x_coord == '0) || (req.y_coord == '0);
                        more_next = !bad_next && (xc_ext <= xl_ext) && (yc_ext <= yl_ext);
                        xi_next   = xc_ext;
                        yi_next   = yc_ext;
                        ys_next   = yc_ext;
                    end
                    else
                    begin
                        bad_next  = 1'b0;
                        more_next = (xs_clamp != '0) && (ys_clamp != '0);
                        xi_next   = xs_clamp;
                        yi_next   = ys_clamp;
                        ys_next   = ys_clamp;
                    end
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (pend_reg && (op_reg == OP_QUERY) && (mem_rdata > best_reg))
                begin
                    best_next = mem_rdata;
                end
                pend_next      = more_reg;
                pend_addr_next = node_addr;
                if (more_reg)
                begin
                    if (y_wrap)
                    begin
                        xi_next   = x_step;
                        yi_next   = ys_reg;
                        more_next = !x_end;
                    end
                    else
                    begin
                        yi_next = y_step;
                    end
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_max_next   = MAX_BITS'(best_reg);
                    rsp_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= 1'b0;
            xi_reg        <= '0;
            yi_reg        <= '0;
            ys_reg        <= '0;
            val_reg       <= '0;
            best_reg      <= '0;
            bad_reg       <= 1'b0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_max_reg   <= '0;
            rsp_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            xi_reg        <= xi_next;
            yi_reg        <= yi_next;
            ys_reg        <= ys_next;
            val_reg       <= val_next;
            best_reg      <= best_next;
            bad_reg       <= bad_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_max_reg   <= rsp_max_next;
            rsp_bad_reg   <= rsp_bad_next;
        end
    end

endmodule

@@ rtl/core/fenwick_2d_prefix_max_table.sv @@
// Top level: limit registers, walk sequencer and node memory.
// Flow: after a request is accepted, the walk touches N nodes (up to 90 at the default
// size), then the result is loaded into the response register.
// A new request is taken only after that load, which waits while a response is untaken.
// Reset: limits return to 256 and 512; a clearing pass then zeroes X_SIZE*Y_SIZE nodes,
// one per cycle, while requests are held off.
`timescale 1ns / 1ps

module fenwick_2d_prefix_max_table import fw2d_pkg::*;
#(
    parameter int X_SIZE     = X_SIZE_DEF,
    parameter int Y_SIZE     = Y_SIZE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    fw2d_req_if.sink                  req,
    fw2d_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int XLW   = $clog2(X_SIZE + 1);
    localparam int YLW   = $clog2(Y_SIZE + 1);
    localparam int AW    = $clog2(X_SIZE * Y_SIZE);
    localparam int XCMPW = (X_LIMIT_BITS > XLW) ? X_LIMIT_BITS : XLW;
    localparam int YCMPW = (Y_LIMIT_BITS > YLW) ? Y_LIMIT_BITS : YLW;

    logic [X_LIMIT_BITS-1:0] x_limit_reg, x_limit_next;
    logic [Y_LIMIT_BITS-1:0] y_limit_reg, y_limit_next;
    logic [XLW-1:0]          x_lim;
    logic [YLW-1:0]          y_lim;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    always_comb
    begin
        x_limit_next = x_limit_reg;
        y_limit_next = y_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_LIMIT: x_limit_next = X_LIMIT_BITS'(cfg_data);
                CFG_Y_LIMIT: y_limit_next = Y_LIMIT_BITS'(cfg_data);
                default:
                begin
                    x_limit_next = x_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else
        begin
            x_limit_reg <= x_limit_next;
            y_limit_reg <= y_limit_next;
        end
    end

    assign x_lim = (XCMPW'(x_limit_reg) > XCMPW'(X_SIZE)) ? XLW'(X_SIZE)
                                                          : XLW'(x_limit_reg);
    assign y_lim = (YCMPW'(y_limit_reg) > YCMPW'(Y_SIZE)) ? YLW'(Y_SIZE)
                                                          : YLW'(y_limit_reg);

    fw2d_walk
    #(
        .X_SIZE     (X_SIZE),
        .Y_SIZE     (Y_SIZE),
        .VALUE_BITS (VALUE_BITS),
        .XLW        (XLW),
        .YLW        (YLW),
        .AW         (AW)
    )
    u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .x_lim     (x_lim),
        .y_lim     (y_lim),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    fw2d_ram
    #(
        .DEPTH (X_SIZE * Y_SIZE),
        .AW    (AW),
        .DW    (VALUE_BITS)
    )
    u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ test/fw2d_table_checker.sv @@
// Checker for the prefix maximum table: predicts every response and compares it.
`timescale 1ns / 1ps

module fw2d_table_checker import fw2d_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    fw2d_req_if                       req,
    fw2d_rsp_if                       rsp,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed
    {
        logic [MAX_BITS-1:0] max_found;
        logic                bad_index;
    } table_result_t;

    bit   [MAX_BITS-1:0]     cell_max [X_SIZE_DEF*Y_SIZE_DEF];
    logic [X_LIMIT_BITS-1:0] x_lim;
    logic [Y_LIMIT_BITS-1:0] y_lim;
    table_result_t           expected_results [$];

    function automatic int cell_index(int x, int y);
        return (x - 1) * Y_SIZE_DEF + (y - 1);
    endfunction

    function automatic table_result_t apply_table_op(logic op, logic [X_COORD_BITS-1:0] xc,
                                                      logic [Y_COORD_BITS-1:0] yc,
                                                      logic [NEW_VALUE_BITS-1:0] val);
        table_result_t res;
        int            xs;
        int            ys;
        int            xi;
        int            yi;
        int            k;
        res.max_found = '0;
        res.bad_index = 1'b0;
        if (op_t'(op) == OP_QUERY)
        begin
            xs = (xc > X_SIZE_DEF) ? X_SIZE_DEF : int'(xc);
            ys = (yc > Y_SIZE_DEF) ? Y_SIZE_DEF : int'(yc);
            for (xi = xs; xi > 0; xi -= xi & -xi)
            begin
                for (yi = ys; yi > 0; yi -= yi & -yi)
                begin
                    k = cell_index(xi, yi);
                    if (cell_max[k] > res.max_found)
                        res.max_found = cell_max[k];
                end
            end
        end
        else if (xc == 0 || yc == 0)
        begin
            res.bad_index = 1'b1;
        end
        else
        begin
            xs = (x_lim > X_SIZE_DEF) ? X_SIZE_DEF : int'(x_lim);
            ys = (y_lim > Y_SIZE_DEF) ? Y_SIZE_DEF : int'(y_lim);
            for (xi = int'(xc); xi <= xs; xi += xi & -xi)
            begin
                for (yi = int'(yc); yi <= ys; yi += yi & -yi)
                begin
                    k = cell_index(xi, yi);
                    if (cell_max[k] < val)
                        cell_max[k] = val;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t ns: %s got 0x%0h, predicted 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        table_result_t want;
        if (!rst_n)
        begin
            foreach (cell_max[i])
                cell_max[i] = '0;
            x_lim = X_LIMIT_RST;
            y_lim = Y_LIMIT_RST;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("response with no request outstanding", rsp.max_found, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.max_found !== want.max_found)
                        report_mismatch("max_found", rsp.max_found, want.max_found);
                    if (rsp.bad_index !== want.bad_index)
                        report_mismatch("bad_index", rsp.bad_index, want.bad_index);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                expected_results = {expected_results,
                                    apply_table_op(req.op, req.x_coord, req.y_coord,
                                                   req.new_value)};
            if (cfg_we === 1'b1)
            begin
                if (cfg_reg_t'(cfg_index) == CFG_X_LIMIT)
                    x_lim = cfg_data[X_LIMIT_BITS-1:0];
                else
                    y_lim = cfg_data[Y_LIMIT_BITS-1:0];
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ test/tb_fenwick_2d_prefix_max_table.sv @@
// Testbench top for the prefix maximum table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fenwick_2d_prefix_max_table;
    import fw2d_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int X_FIELD_MAX = (1 << X_COORD_BITS) - 1;
    localparam int Y_FIELD_MAX = (1 << Y_COORD_BITS) - 1;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending;
    int                        idle_cycles = 0;
    int                        sent = 0;
    int                        quiet_left = 0;

    fw2d_req_if req_ch ();
    fw2d_rsp_if rsp_ch ();

    fenwick_2d_prefix_max_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fw2d_table_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
        begin
            quiet_left = 40;
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic int pick_coord(int top, int field_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 0;
        if (r < 10)
            return $urandom_range(top + 1, field_max);
        if (r < 30)
            return $urandom_range(1, (top < 16) ? top : 16);
        return $urandom_range(1, top);
    endfunction

    function automatic int pick_value();
        int top;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        top = 200 + sent * 40;
        return $urandom_range(0, (top > 65535) ? 65535 : top);
    endfunction

    task automatic send_request(op_t op, int x, int y, int v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.x_coord   <= X_COORD_BITS'(x);
        req_ch.y_coord   <= Y_COORD_BITS'(y);
        req_ch.new_value <= NEW_VALUE_BITS'(v);
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sent++;
    endtask

    task automatic finish_burst();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic set_limit(cfg_reg_t idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(int xlim, int ylim, int count);
        int xtop;
        int ytop;
        finish_burst();
        set_limit(CFG_X_LIMIT, xlim);
        set_limit(CFG_Y_LIMIT, ylim);
        xtop = (xlim > X_SIZE_DEF) ? X_SIZE_DEF : ((xlim < 1) ? 1 : xlim);
        ytop = (ylim > Y_SIZE_DEF) ? Y_SIZE_DEF : ((ylim < 1) ? 1 : ylim);
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0)
                send_request(OP_QUERY, pick_coord(X_SIZE_DEF, X_FIELD_MAX),
                             pick_coord(Y_SIZE_DEF, Y_FIELD_MAX), $urandom_range(0, 65535));
            else
                send_request(OP_UPDATE, pick_coord(xtop, X_FIELD_MAX),
                             pick_coord(ytop, Y_FIELD_MAX), pick_value());
        end
    endtask

    initial
    begin : rsp_pacing
        int run;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            run = pick_stall();
            repeat (run)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800) : $urandom_range(1, 12);
            repeat (run)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= OP_QUERY;
        req_ch.x_coord   <= '0;
        req_ch.y_coord   <= '0;
        req_ch.new_value <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_X_LIMIT;
        cfg_data         <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(OP_QUERY, 0, 0, 0);
        send_request(OP_QUERY, 256, 512, 0);
        send_request(OP_UPDATE, 256, 512, 16'hFFFF);
        send_request(OP_QUERY, 255, 511, 0);
        send_request(OP_QUERY, 256, 512, 0);
        send_request(OP_QUERY, X_FIELD_MAX, Y_FIELD_MAX, 0);
        send_request(OP_UPDATE, 0, 5, 16'h1234);
        send_request(OP_UPDATE, 5, 0, 16'h1234);
        send_request(OP_UPDATE, 0, 0, 16'hFFFF);
        send_request(OP_UPDATE, 300, 10, 16'h7777);
        send_request(OP_UPDATE, 10, 600, 16'h7777);
        send_request(OP_QUERY, 300, 600, 0);
        send_request(OP_UPDATE, 3, 7, 16'h1234);
        send_request(OP_QUERY, 3, 7, 0);
        send_request(OP_QUERY, 2, 7, 0);
        send_request(OP_QUERY, 3, 6, 0);
        send_request(OP_QUERY, 0, 7, 0);
        send_request(OP_QUERY, 3, 0, 0);
        send_request(OP_UPDATE, 1, 1, 0);
        send_request(OP_UPDATE, 128, 256, 16'h00FF);
        send_request(OP_QUERY, 200, 300, 0);
        send_request(OP_UPDATE, 1, 1, 16'h0001);
        send_request(OP_QUERY, 1, 1, 0);
        send_request(OP_QUERY, 257, 513, 16'hFFFF);

        run_phase(256, 512, 450);
        run_phase(1, 1, 150);
        run_phase(X_FIELD_MAX, Y_FIELD_MAX, 300);
        run_phase(0, 0, 100);
        run_phase($urandom_range(1, 256), $urandom_range(1, 512), 300);
        run_phase($urandom_range(2, 40), $urandom_range(2, 40), 200);
        run_phase(256, 512, 200);

        finish_burst();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ fenwick_2d_prefix_max_table.f @@
rtl/core/fw2d_pkg.sv
rtl/core/fw2d_if.sv
rtl/core/fw2d_ram.sv
rtl/core/fw2d_walk.sv
rtl/core/fenwick_2d_prefix_max_table.sv
test/fw2d_table_checker.sv
test/tb_fenwick_2d_prefix_max_table.sv
